@@ hdl/r2e_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// r2e_pkg
// Shared types, widths and the arctangent table of the rotation matrix to
// Euler angle converter.
// ----------------------------------------------------------------------------
package r2e_pkg;

    localparam int EW               = 16;
    localparam int OW               = 17;
    localparam int CW               = 34;
    localparam int ZW               = 28;
    localparam int TW               = 15;
    localparam int SQ_STEPS         = 25;
    localparam int SQ_LAT           = SQ_STEPS + 1;
    localparam int VW               = 50;
    localparam int MAX_STEPS        = 24;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int OUT_LIMIT        = 25736;

    localparam logic signed [ZW-1:0] PI_HALF = 28'sd26353589;

    localparam logic CFG_DEFAULT_ORDER  = 1'b0;
    localparam logic CFG_LOCK_THRESHOLD = 1'b1;

    typedef enum logic [2:0] {
        ORD_XYZ,
        ORD_YXZ,
        ORD_ZXY,
        ORD_ZYX,
        ORD_YZX,
        ORD_XZY
    } t_order;

    typedef struct packed {
        t_order ord;
        logic   lk;
    } t_route;

    typedef struct packed {
        logic signed [OW-1:0] a;
        logic signed [OW-1:0] b;
    } t_pair;

    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = 28'sd13176795;
            1:       v = 28'sd7778716;
            2:       v = 28'sd4110060;
            3:       v = 28'sd2086331;
            4:       v = 28'sd1047214;
            5:       v = 28'sd524117;
            6:       v = 28'sd262123;
            7:       v = 28'sd131069;
            default: v = ZW'(28'sd65536 >>> (idx - 8));
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hdl/r2e_select.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// r2e_select
// Input stage: resolves the rotation order, picks the pivot, tests for
// gimbal lock and selects the operand pairs of both arctangent units.
// ----------------------------------------------------------------------------
module r2e_select
    import r2e_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic signed [EW-1:0] i_r11,
    input  wire logic signed [EW-1:0] i_r12,
    input  wire logic signed [EW-1:0] i_r13,
    input  wire logic signed [EW-1:0] i_r21,
    input  wire logic signed [EW-1:0] i_r22,
    input  wire logic signed [EW-1:0] i_r23,
    input  wire logic signed [EW-1:0] i_r31,
    input  wire logic signed [EW-1:0] i_r32,
    input  wire logic signed [EW-1:0] i_r33,
    input  wire logic [2:0]           i_order,
    input  wire logic [2:0]           i_default_order,
    input  wire logic [TW-1:0]        i_threshold,
    output logic                      o_valid,
    output logic signed [EW-1:0]      o_s,
    output t_pair                     o_pa,
    output t_pair                     o_pb,
    output t_route                    o_route
);

    function automatic logic signed [OW-1:0] ext(input logic signed [EW-1:0] v);
        return OW'(v);
    endfunction

    function automatic logic signed [OW-1:0] neg(input logic signed [EW-1:0] v);
        return -OW'(v);
    endfunction

    logic                 r_valid;
    logic signed [EW-1:0] r_s,     n_s;
    t_pair                r_pa,    n_pa;
    t_pair                r_pb,    n_pb;
    t_route               r_route, n_route;

    always_comb begin
        t_order               ord;
        logic signed [EW-1:0] p;
        logic signed [OW-1:0] ap;
        logic                 lk;
        logic                 sneg;
        logic signed [EW-1:0] s;
        if (i_order > 3'd5) begin
            ord = (i_default_order > 3'd5) ? ORD_XYZ : t_order'(i_default_order);
        end else begin
            ord = t_order'(i_order);
        end
        unique case (ord)
            ORD_XYZ: p = i_r13;
            ORD_YXZ: p = i_r23;
            ORD_ZXY: p = i_r32;
            ORD_ZYX: p = i_r31;
            ORD_YZX: p = i_r21;
            default: p = i_r12;
        endcase
        ap   = p[EW-1] ? neg(p) : ext(p);
        lk   = ap >= $signed({2'b00, i_threshold});
        sneg = (ord == ORD_YXZ) || (ord == ORD_ZYX) || (ord == ORD_XZY);
        if (p > 16'sd16384) begin
            s = 16'sd16384;
        end else if (p < -16'sd16384) begin
            s = -16'sd16384;
        end else begin
            s = p;
        end
        n_s  = sneg ? -s : s;
        n_pa = '0;
        n_pb = '0;
        unique case (ord)
            ORD_XYZ: begin
                if (!lk) begin
                    n_pa = '{neg(i_r23), ext(i_r33)};
                    n_pb = '{neg(i_r12), ext(i_r11)};
                end else begin
                    n_pa = '{ext(i_r32), ext(i_r22)};
                end
            end
            ORD_YXZ: begin
                if (!lk) begin
                    n_pa = '{ext(i_r13), ext(i_r33)};
                    n_pb = '{ext(i_r21), ext(i_r22)};
                end else begin
                    n_pa = '{neg(i_r31), ext(i_r11)};
                end
            end
            ORD_ZXY: begin
                if (!lk) begin
                    n_pa = '{neg(i_r31), ext(i_r33)};
                    n_pb = '{neg(i_r12), ext(i_r22)};
                end else begin
                    n_pb = '{ext(i_r21), ext(i_r11)};
                end
            end
            ORD_ZYX: begin
                if (!lk) begin
                    n_pa = '{ext(i_r32), ext(i_r33)};
                    n_pb = '{ext(i_r21), ext(i_r11)};
                end else begin
                    n_pb = '{neg(i_r12), ext(i_r22)};
                end
            end
            ORD_YZX: begin
                if (!lk) begin
                    n_pa = '{neg(i_r23), ext(i_r22)};
                    n_pb = '{neg(i_r31), ext(i_r11)};
                end else begin
                    n_pb = '{ext(i_r13), ext(i_r33)};
                end
            end
            default: begin
                if (!lk) begin
                    n_pa = '{ext(i_r32), ext(i_r22)};
                    n_pb = '{ext(i_r13), ext(i_r11)};
                end else begin
                    n_pa = '{neg(i_r23), ext(i_r33)};
                end
            end
        endcase
        n_route = '{ord, lk};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_s     <= n_s;
        r_pa    <= n_pa;
        r_pb    <= n_pb;
        r_route <= n_route;
    end

    assign o_valid = r_valid;
    assign o_s     = r_s;
    assign o_pa    = r_pa;
    assign o_pb    = r_pb;
    assign o_route = r_route;

endmodule
`default_nettype wire

@@ hdl/r2e_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// r2e_sqrt
// Pipelined cosine of the pivot: squares the sine, then takes the integer
// square root of the scaled remainder one result bit per stage.
// ----------------------------------------------------------------------------
module r2e_sqrt
    import r2e_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic signed [EW-1:0] i_s,
    output logic                      o_valid,
    output logic signed [EW-1:0]      o_s,
    output logic [SQ_STEPS-1:0]       o_c
);

    logic                 r_vld [0:SQ_STEPS];
    logic signed [EW-1:0] r_s   [0:SQ_STEPS];
    logic [VW-1:0]        r_v   [0:SQ_STEPS];
    logic [VW-1:0]        r_r   [0:SQ_STEPS];

    logic [2*EW-1:0] n_sq;
    logic [VW-1:0]   n_v;

    always_comb begin
        n_sq = 32'(i_s * i_s);
        n_v  = (VW'(32'd268435456) - VW'(n_sq)) << 20;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_s[0] <= i_s;
        r_v[0] <= n_v;
        r_r[0] <= '0;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [VW-1:0] BIT = VW'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [VW-1:0] n_t;
        assign n_t = r_r[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_s[k+1] <= r_s[k];
            if (r_v[k] >= n_t) begin
                r_v[k+1] <= r_v[k] - n_t;
                r_r[k+1] <= (r_r[k] >> 1) + BIT;
            end else begin
                r_v[k+1] <= r_v[k];
                r_r[k+1] <= r_r[k] >> 1;
            end
        end
    end

    assign o_valid = r_vld[SQ_STEPS];
    assign o_s     = r_s[SQ_STEPS];
    assign o_c     = r_r[SQ_STEPS][SQ_STEPS-1:0];

endmodule
`default_nettype wire

@@ hdl/r2e_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// r2e_cordic
// Pipelined vectoring CORDIC for atan2: a quadrant pre-rotation stage and
// one micro-rotation per stage.
// ----------------------------------------------------------------------------
module r2e_cordic
    import r2e_pkg::*;
#(
    parameter int NSTEP = CORDIC_STEPS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic signed [CW-1:0] i_y,
    input  wire logic signed [CW-1:0] i_x,
    output logic                      o_valid,
    output logic signed [ZW-1:0]      o_z
);

    logic                 r_vld  [0:NSTEP];
    logic                 r_zero [0:NSTEP];
    logic signed [CW-1:0] r_x    [0:NSTEP];
    logic signed [CW-1:0] r_y    [0:NSTEP];
    logic signed [ZW-1:0] r_z    [0:NSTEP];

    logic signed [CW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;

    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x = i_y;
                n_y = -i_x;
                n_z = PI_HALF;
            end else begin
                n_x = -i_y;
                n_y = i_x;
                n_z = -PI_HALF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_zero[0] <= (i_x == 0) && (i_y == 0);
        r_x[0]    <= n_x;
        r_y[0]    <= n_y;
        r_z[0]    <= n_z;
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        localparam logic signed [ZW-1:0] ANG = atan_entry(i);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            r_zero[i+1] <= r_zero[i];
            if (r_y[i] >= 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + ANG;
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - ANG;
            end
        end
    end

    assign o_valid = r_vld[NSTEP];
    assign o_z     = r_zero[NSTEP] ? '0 : r_z[NSTEP];

endmodule
`default_nettype wire

@@ hdl/rotation_matrix_to_euler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler
// Converts a Q2.14 rotation matrix into Q3.13 Euler angles for a selectable
// rotation order, with gimbal lock detection.
// ----------------------------------------------------------------------------
// A matrix is taken in every cycle at which start is high; busy is always
// low. The result appears on the o_ ports for one cycle, marked by o_valid,
// after the accepted beat has passed one select stage, a square stage and
// 25 square root stages, the CORDIC pre-rotation and one stage per CORDIC
// step, and the output rounding stage. Results must be taken when shown.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler
    import r2e_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [EW-1:0] i_r11,
    input  wire logic signed [EW-1:0] i_r12,
    input  wire logic signed [EW-1:0] i_r13,
    input  wire logic signed [EW-1:0] i_r21,
    input  wire logic signed [EW-1:0] i_r22,
    input  wire logic signed [EW-1:0] i_r23,
    input  wire logic signed [EW-1:0] i_r31,
    input  wire logic signed [EW-1:0] i_r32,
    input  wire logic signed [EW-1:0] i_r33,
    input  wire logic [2:0]           i_rotation_order,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [TW-1:0]        i_cfg_data,
    output logic                      o_valid,
    output logic signed [EW-1:0]      o_angle_x,
    output logic signed [EW-1:0]      o_angle_y,
    output logic signed [EW-1:0]      o_angle_z,
    output logic                      o_gimbal_locked
);

    localparam int NSTEP  = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int RT_LAT = SQ_LAT + 1 + NSTEP;
    localparam int LAT    = RT_LAT + 2;

    function automatic logic signed [EW-1:0] to_out(input logic signed [ZW-1:0] a);
        logic [ZW:0] m;
        logic [ZW:0] r;
        logic [EW-1:0] q;
        m = a[ZW-1] ? -(ZW+1)'(a) : (ZW+1)'(a);
        r = (m + (ZW+1)'(1024)) >> 11;
        q = (r > (ZW+1)'(OUT_LIMIT)) ? EW'(OUT_LIMIT) : r[EW-1:0];
        return a[ZW-1] ? -$signed(q) : $signed(q);
    endfunction

    logic [2:0]    r_default_order;
    logic [TW-1:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_order <= 3'd0;
            r_threshold     <= TW'(16384);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEFAULT_ORDER:  r_default_order <= i_cfg_data[2:0];
                CFG_LOCK_THRESHOLD: r_threshold     <= i_cfg_data;
                default:            r_threshold     <= r_threshold;
            endcase
        end
    end

    assign busy = 1'b0;

    logic                 a_valid;
    logic signed [EW-1:0] a_s;
    t_pair                a_pa, a_pb;
    t_route               a_route;

    r2e_select u_select (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start && !busy),
        .i_r11           (i_r11),
        .i_r12           (i_r12),
        .i_r13           (i_r13),
        .i_r21           (i_r21),
        .i_r22           (i_r22),
        .i_r23           (i_r23),
        .i_r31           (i_r31),
        .i_r32           (i_r32),
        .i_r33           (i_r33),
        .i_order         (i_rotation_order),
        .i_default_order (r_default_order),
        .i_threshold     (r_threshold),
        .o_valid         (a_valid),
        .o_s             (a_s),
        .o_pa            (a_pa),
        .o_pb            (a_pb),
        .o_route         (a_route)
    );

    logic                 q_valid;
    logic signed [EW-1:0] q_s;
    logic [SQ_STEPS-1:0]  q_c;

    r2e_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (a_valid),
        .i_s     (a_s),
        .o_valid (q_valid),
        .o_s     (q_s),
        .o_c     (q_c)
    );

    t_pair  r_dpa [0:SQ_LAT-1];
    t_pair  r_dpb [0:SQ_LAT-1];
    t_route r_drt [0:RT_LAT-1];

    always_ff @(posedge i_clk) begin
        r_dpa[0] <= a_pa;
        r_dpb[0] <= a_pb;
        r_drt[0] <= a_route;
        for (int k = 1; k < SQ_LAT; k++) begin
            r_dpa[k] <= r_dpa[k-1];
            r_dpb[k] <= r_dpb[k-1];
        end
        for (int k = 1; k < RT_LAT; k++) begin
            r_drt[k] <= r_drt[k-1];
        end
    end

    t_pair                d_pa, d_pb;
    logic signed [CW-1:0] c_sy, c_sx, c_ay, c_ax, c_by, c_bx;

    always_comb begin
        d_pa = r_dpa[SQ_LAT-1];
        d_pb = r_dpb[SQ_LAT-1];
        c_sy = $signed({{(CW-EW-10){q_s[EW-1]}}, q_s, 10'b0});
        c_sx = $signed({{(CW-SQ_STEPS){1'b0}}, q_c});
        c_ay = $signed({{(CW-OW-14){d_pa.a[OW-1]}}, d_pa.a, 14'b0});
        c_ax = $signed({{(CW-OW-14){d_pa.b[OW-1]}}, d_pa.b, 14'b0});
        c_by = $signed({{(CW-OW-14){d_pb.a[OW-1]}}, d_pb.a, 14'b0});
        c_bx = $signed({{(CW-OW-14){d_pb.b[OW-1]}}, d_pb.b, 14'b0});
    end

    logic                 s_valid, ua_valid, ub_valid;
    logic signed [ZW-1:0] s_z, ua_z, ub_z;

    r2e_cordic #(.NSTEP(NSTEP)) u_cordic_asin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_y     (c_sy),
        .i_x     (c_sx),
        .o_valid (s_valid),
        .o_z     (s_z)
    );

    r2e_cordic #(.NSTEP(NSTEP)) u_cordic_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_y     (c_ay),
        .i_x     (c_ax),
        .o_valid (ua_valid),
        .o_z     (ua_z)
    );

    r2e_cordic #(.NSTEP(NSTEP)) u_cordic_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_y     (c_by),
        .i_x     (c_bx),
        .o_valid (ub_valid),
        .o_z     (ub_z)
    );

    logic                 r_valid;
    logic signed [EW-1:0] r_ax, r_ay, r_az;
    logic signed [EW-1:0] n_ax, n_ay, n_az;
    logic                 r_lk;
    t_route               e_route;

    always_comb begin
        e_route = r_drt[RT_LAT-1];
        n_ax    = to_out(ua_z);
        n_ay    = to_out(ub_z);
        n_az    = to_out(ub_z);
        case (e_route.ord) inside
            ORD_XYZ, ORD_ZYX: begin
                n_ax = to_out(ua_z);
                n_ay = to_out(s_z);
            end
            ORD_YXZ, ORD_ZXY: begin
                n_ax = to_out(s_z);
                n_ay = to_out(ua_z);
            end
            default: begin
                n_ax = to_out(ua_z);
                n_ay = to_out(ub_z);
                n_az = to_out(s_z);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s_valid && ua_valid && ub_valid;
        end
        r_ax <= n_ax;
        r_ay <= n_ay;
        r_az <= n_az;
        r_lk <= e_route.lk;
    end

    assign o_valid         = r_valid;
    assign o_angle_x       = r_ax;
    assign o_angle_y       = r_ay;
    assign o_angle_z       = r_az;
    assign o_gimbal_locked = r_lk;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("Result beat without a matching input beat.");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle_x <= 16'sd25736) && (o_angle_x >= -16'sd25736) &&
                    (o_angle_y <= 16'sd25736) && (o_angle_y >= -16'sd25736) &&
                    (o_angle_z <= 16'sd25736) && (o_angle_z >= -16'sd25736))
        else $error("Angle outside the saturation limit.");

    a_locked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gimbal_locked) |->
            (o_angle_x == 0) || (o_angle_y == 0) || (o_angle_z == 0))
        else $error("Gimbal lock result without a zero angle.");

endmodule
`default_nettype wire

@@ verif/rotation_matrix_to_euler_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_check
// Watches the command, configuration and result ports of the converter,
// computes the expected Euler angles of every accepted matrix and compares
// each result beat with the oldest expected one.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_check
    import r2e_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire logic signed [EW-1:0] i_r11,
    input  wire logic signed [EW-1:0] i_r12,
    input  wire logic signed [EW-1:0] i_r13,
    input  wire logic signed [EW-1:0] i_r21,
    input  wire logic signed [EW-1:0] i_r22,
    input  wire logic signed [EW-1:0] i_r23,
    input  wire logic signed [EW-1:0] i_r31,
    input  wire logic signed [EW-1:0] i_r32,
    input  wire logic signed [EW-1:0] i_r33,
    input  wire logic [2:0]           i_rotation_order,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [TW-1:0]        i_cfg_data,
    input  wire logic                 i_valid,
    input  wire logic signed [EW-1:0] i_angle_x,
    input  wire logic signed [EW-1:0] i_angle_y,
    input  wire logic signed [EW-1:0] i_angle_z,
    input  wire logic                 i_gimbal_locked,
    output int                        o_errors,
    output int                        o_pending
);

    typedef struct {
        logic signed [EW-1:0] ax;
        logic signed [EW-1:0] ay;
        logic signed [EW-1:0] az;
        logic                 lk;
    } t_angles;

    t_angles angles_due[$];
    logic [2:0] def_order;
    logic [TW-1:0] lock_thr;

    localparam longint ATAN_VALS[24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    function automatic longint vector_angle(longint y_in, longint x_in);
        longint y, x, z, t, xs, ys;
        y = y_in;
        x = x_in;
        z = 0;
        if (x == 0 && y == 0) begin
            return 0;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = PI_HALF;
            end else begin
                x = -y; y = t; z = -PI_HALF;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < MAX_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += ATAN_VALS[i];
            end else begin
                x = x - ys; y = y + xs; z -= ATAN_VALS[i];
            end
        end
        return z;
    endfunction

    function automatic longint pair_angle(longint a, longint b);
        return vector_angle(a * 16384, b * 16384);
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            if ((r + (64'sd1 <<< k)) * (r + (64'sd1 <<< k)) <= v) begin
                r = r + (64'sd1 <<< k);
            end
        end
        return r;
    endfunction

    function automatic longint pivot_angle(longint p, bit neg);
        longint s;
        s = p;
        if (s > 16384) s = 16384;
        if (s < -16384) s = -16384;
        if (neg) s = -s;
        return vector_angle(s * 1024, root_floor((268435456 - s * s) <<< 20));
    endfunction

    function automatic logic signed [EW-1:0] round_q13(longint a);
        longint r;
        if (a < 0) r = -((-a + 1024) >>> 11);
        else r = (a + 1024) >>> 11;
        if (r > OUT_LIMIT) r = OUT_LIMIT;
        if (r < -OUT_LIMIT) r = -OUT_LIMIT;
        return EW'(r);
    endfunction

    function automatic t_angles euler_of(longint m11, longint m12, longint m13,
                                         longint m21, longint m22, longint m23,
                                         longint m31, longint m32, longint m33,
                                         logic [2:0] code);
        t_order ord;
        longint ax, ay, az, p;
        bit lk;
        t_angles res;
        ax = 0; ay = 0; az = 0;
        if (code > 3'(ORD_XZY)) code = def_order;
        if (code > 3'(ORD_XZY)) code = 3'(ORD_XYZ);
        ord = t_order'(code);
        case (ord)
            ORD_XYZ: p = m13;
            ORD_YXZ: p = m23;
            ORD_ZXY: p = m32;
            ORD_ZYX: p = m31;
            ORD_YZX: p = m21;
            default: p = m12;
        endcase
        lk = ((p < 0) ? -p : p) >= longint'(lock_thr);
        case (ord)
            ORD_XYZ: begin
                ay = pivot_angle(p, 0);
                if (!lk) begin
                    ax = pair_angle(-m23, m33); az = pair_angle(-m12, m11);
                end else ax = pair_angle(m32, m22);
            end
            ORD_YXZ: begin
                ax = pivot_angle(p, 1);
                if (!lk) begin
                    ay = pair_angle(m13, m33); az = pair_angle(m21, m22);
                end else ay = pair_angle(-m31, m11);
            end
            ORD_ZXY: begin
                ax = pivot_angle(p, 0);
                if (!lk) begin
                    ay = pair_angle(-m31, m33); az = pair_angle(-m12, m22);
                end else az = pair_angle(m21, m11);
            end
            ORD_ZYX: begin
                ay = pivot_angle(p, 1);
                if (!lk) begin
                    ax = pair_angle(m32, m33); az = pair_angle(m21, m11);
                end else az = pair_angle(-m12, m22);
            end
            ORD_YZX: begin
                az = pivot_angle(p, 0);
                if (!lk) begin
                    ax = pair_angle(-m23, m22); ay = pair_angle(-m31, m11);
                end else ay = pair_angle(m13, m33);
            end
            default: begin
                az = pivot_angle(p, 1);
                if (!lk) begin
                    ax = pair_angle(m32, m22); ay = pair_angle(m13, m11);
                end else ax = pair_angle(-m23, m33);
            end
        endcase
        res.ax = round_q13(ax);
        res.ay = round_q13(ay);
        res.az = round_q13(az);
        res.lk = lk;
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = angles_due.size();

    always @(posedge i_clk) begin
        t_angles want;
        if (!i_rst_n) begin
            def_order <= 3'(ORD_XYZ);
            lock_thr  <= TW'(16384);
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DEFAULT_ORDER) def_order <= i_cfg_data[2:0];
                else lock_thr <= i_cfg_data;
            end
            if (i_start && !i_busy) begin
                angles_due.push_back(euler_of(i_r11, i_r12, i_r13, i_r21, i_r22,
                    i_r23, i_r31, i_r32, i_r33, i_rotation_order));
            end
            if (i_valid) begin
                if (angles_due.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = angles_due.pop_front();
                    if (i_angle_x !== want.ax)
                        report_mismatch($sformatf("angle_x %0d, expected %0d",
                            i_angle_x, want.ax));
                    if (i_angle_y !== want.ay)
                        report_mismatch($sformatf("angle_y %0d, expected %0d",
                            i_angle_y, want.ay));
                    if (i_angle_z !== want.az)
                        report_mismatch($sformatf("angle_z %0d, expected %0d",
                            i_angle_z, want.az));
                    if (i_gimbal_locked !== want.lk)
                        report_mismatch($sformatf("gimbal_locked %0b, expected %0b",
                            i_gimbal_locked, want.lk));
                end
            end
        end
    end

endmodule

@@ verif/rotation_matrix_to_euler_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_test
// Drives directed and random rotation matrices through the converter under
// several register settings with random gaps; a checker alongside predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_test;
    import r2e_pkg::*;

    localparam int LATENCY = 29 + ((CORDIC_STEPS_DEF < MAX_STEPS) ?
                                   CORDIC_STEPS_DEF : MAX_STEPS);
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [EW-1:0] r11 = 0, r12 = 0, r13 = 0, r21 = 0, r22 = 0;
    logic signed [EW-1:0] r23 = 0, r31 = 0, r32 = 0, r33 = 0;
    logic [2:0] rot_order = 0;
    logic cfg_we = 0;
    logic cfg_idx = 0;
    logic [TW-1:0] cfg_data = 0;
    logic o_valid, o_gimbal_locked;
    logic signed [EW-1:0] o_angle_x, o_angle_y, o_angle_z;
    int errors, pending, idle_cycles;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    rotation_matrix_to_euler dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_r11(r11), .i_r12(r12), .i_r13(r13), .i_r21(r21), .i_r22(r22),
        .i_r23(r23), .i_r31(r31), .i_r32(r32), .i_r33(r33),
        .i_rotation_order(rot_order), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .o_valid, .o_angle_x, .o_angle_y, .o_angle_z,
        .o_gimbal_locked
    );

    rotation_matrix_to_euler_check checker_i (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy),
        .i_r11(r11), .i_r12(r12), .i_r13(r13), .i_r21(r21), .i_r22(r22),
        .i_r23(r23), .i_r31(r31), .i_r32(r32), .i_r33(r33),
        .i_rotation_order(rot_order), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(o_valid), .i_angle_x(o_angle_x),
        .i_angle_y(o_angle_y), .i_angle_z(o_angle_z),
        .i_gimbal_locked(o_gimbal_locked), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rotation_matrix_to_euler_test NOT OK");
            $finish;
        end
    end

    task automatic random_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 60) n = 0;
        else if (n < 95) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 60);
        if (n > 0) begin
            start <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_matrix(logic signed [EW-1:0] m[9], logic [2:0] code);
        start <= 1;
        r11 <= m[0]; r12 <= m[1]; r13 <= m[2];
        r21 <= m[3]; r22 <= m[4]; r23 <= m[5];
        r31 <= m[6]; r32 <= m[7]; r33 <= m[8];
        rot_order <= code;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(0, 3) != 0) begin
            random_gap();
        end
    endtask

    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [TW-1:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [EW-1:0] pick_element();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sd16384;
            3: return -16'sd16384;
            4: return 16'sd0;
            5, 6: return EW'(int'($urandom_range(0, 32768)) - 16384);
            default: return EW'($urandom);
        endcase
    endfunction

    task automatic send_random(int count);
        logic signed [EW-1:0] m[9];
        for (int n = 0; n < count; n++) begin
            foreach (m[k]) m[k] = pick_element();
            send_matrix(m, 3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        logic signed [EW-1:0] m[9];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Identity and gimbal lock pivots in each order, then extremes and zero vectors.
        for (int c = 0; c < 8; c++) begin
            m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
            send_matrix(m, 3'(c));
        end
        for (int c = 0; c < 6; c++) begin
            m = '{0, 16384, 16384, 16384, 0, 16384, -16384, -16384, 0};
            send_matrix(m, 3'(c));
            m = '{-16384, -16384, -16384, -16384, -16384, -16384, 16384, 16384,
                  -16384};
            send_matrix(m, 3'(c));
        end
        m = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh8000};
        send_matrix(m, 3'd0);
        m = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        send_matrix(m, 3'd7);
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(m, 3'd1);
        m = '{-100, 0, 0, 0, -100, 0, 0, 0, -100};
        send_matrix(m, 3'd0);
        send_random(250);
        drain();

        write_reg(CFG_DEFAULT_ORDER, TW'(ORD_XZY));
        write_reg(CFG_LOCK_THRESHOLD, TW'(0));
        send_random(200);
        drain();

        write_reg(CFG_DEFAULT_ORDER, TW'(7));
        write_reg(CFG_LOCK_THRESHOLD, TW'(16383));
        send_random(200);
        drain();

        write_reg(CFG_DEFAULT_ORDER, TW'(ORD_ZYX));
        write_reg(CFG_LOCK_THRESHOLD, 15'h7FFF);
        send_random(200);
        drain();

        write_reg(CFG_DEFAULT_ORDER, TW'($urandom_range(0, 7)));
        write_reg(CFG_LOCK_THRESHOLD, TW'($urandom_range(12000, 16384)));
        send_random(180);
        drain();

        if (errors == 0) begin
            $display("rotation_matrix_to_euler_test OK");
        end else begin
            $display("rotation_matrix_to_euler_test NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/r2e_pkg.sv
hdl/r2e_select.sv
hdl/r2e_sqrt.sv
hdl/r2e_cordic.sv
hdl/rotation_matrix_to_euler.sv
verif/rotation_matrix_to_euler_check.sv
verif/rotation_matrix_to_euler_test.sv
